>>> design/lzwd_pkg.sv
`default_nettype none
package lzwd_pkg;

  localparam int unsigned WindowBytes = 4096;
  localparam int unsigned OffW        = 12;
  localparam int unsigned LenW        = 4;
  localparam int unsigned QueueDepth  = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_chunk;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_stream;
  } out_t;

  typedef enum logic [1:0] {
    CMD_LIT  = 2'd0,
    CMD_COPY = 2'd1,
    CMD_EOS  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t       kind;
    logic            restart;
    logic [7:0]      lit;
    logic [OffW-1:0] offset;
    logic [LenW-1:0] len_code;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage
`default_nettype wire

>>> design/lzwd_front.sv
`default_nettype none
module lzwd_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire lzwd_pkg::in_t         in_data,
  input  wire lzwd_pkg::back_status_t status,
  input  wire logic                  q_full,
  output logic                       q_push,
  output lzwd_pkg::cmd_t             q_cmd
);

  typedef enum logic [2:0] {
    PH_TAG  = 3'b001,
    PH_ITEM = 3'b010,
    PH_HIGH = 3'b100
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  flag_byte_r, flag_byte_nxt;
  logic [2:0]  flag_pos_r, flag_pos_nxt;
  logic [7:0]  low_r, low_nxt;
  logic        finished_r, finished_nxt;
  logic        restart_pend_r, restart_pend_nxt;

  logic        accept;
  phase_t      ph_eff;
  logic        fin_eff;
  logic [lzwd_pkg::OffW-1:0] token_off;

  assign in_ready  = !status.clearing && !q_full;
  assign accept    = in_valid && in_ready;
  assign token_off = {in_data.in_byte, low_r[7:4]};

  always_comb begin
    phase_nxt        = phase_r;
    flag_byte_nxt    = flag_byte_r;
    flag_pos_nxt     = flag_pos_r;
    low_nxt          = low_r;
    finished_nxt     = finished_r;
    restart_pend_nxt = restart_pend_r;
    q_push           = 1'b0;
    q_cmd.kind       = lzwd_pkg::CMD_LIT;
    q_cmd.restart    = restart_pend_r;
    q_cmd.lit        = in_data.in_byte;
    q_cmd.offset     = token_off;
    q_cmd.len_code   = low_r[lzwd_pkg::LenW-1:0];
    ph_eff           = in_data.start_of_chunk ? PH_TAG : phase_r;
    fin_eff          = in_data.start_of_chunk ? 1'b0 : finished_r;

    if (accept) begin
      if (in_data.start_of_chunk) begin
        finished_nxt     = 1'b0;
        flag_pos_nxt     = 3'd0;
        phase_nxt        = PH_TAG;
        restart_pend_nxt = 1'b1;
      end
      if (!fin_eff) begin
        case (ph_eff)
          PH_ITEM: begin
            if (!flag_byte_r[flag_pos_r]) begin
              q_push     = 1'b1;
              q_cmd.kind = lzwd_pkg::CMD_LIT;
              if (flag_pos_r == 3'd7) begin
                flag_pos_nxt = 3'd0;
                phase_nxt    = PH_TAG;
              end else begin
                flag_pos_nxt = flag_pos_r + 3'd1;
                phase_nxt    = PH_ITEM;
              end
            end else begin
              low_nxt   = in_data.in_byte;
              phase_nxt = PH_HIGH;
            end
          end
          PH_HIGH: begin
            q_push = 1'b1;
            if (token_off == '0) begin
              q_cmd.kind   = lzwd_pkg::CMD_EOS;
              finished_nxt = 1'b1;
              phase_nxt    = PH_TAG;
            end else begin
              q_cmd.kind = lzwd_pkg::CMD_COPY;
              if (flag_pos_r == 3'd7) begin
                flag_pos_nxt = 3'd0;
                phase_nxt    = PH_TAG;
              end else begin
                flag_pos_nxt = flag_pos_r + 3'd1;
                phase_nxt    = PH_ITEM;
              end
            end
          end
          default: begin
            // tag byte, also any stray phase code
            flag_byte_nxt = in_data.in_byte;
            flag_pos_nxt  = 3'd0;
            phase_nxt     = PH_ITEM;
          end
        endcase
        if (q_push) begin
          restart_pend_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_TAG;
      flag_byte_r    <= '0;
      flag_pos_r     <= '0;
      low_r          <= '0;
      finished_r     <= 1'b0;
      restart_pend_r <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      flag_byte_r    <= flag_byte_nxt;
      flag_pos_r     <= flag_pos_nxt;
      low_r          <= low_nxt;
      finished_r     <= finished_nxt;
      restart_pend_r <= restart_pend_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/lzwd_cmd_fifo.sv
`default_nettype none
module lzwd_cmd_fifo #(
  parameter int unsigned DEPTH = lzwd_pkg::QueueDepth
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire lzwd_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output lzwd_pkg::cmd_t      head_cmd
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lzwd_pkg::cmd_t  slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/lzwd_back.sv
`default_nettype none
module lzwd_back #(
  parameter int unsigned WINDOW_BYTES = lzwd_pkg::WindowBytes
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  input  wire lzwd_pkg::cmd_t        q_cmd,
  output logic                       q_pop,
  output lzwd_pkg::back_status_t     status,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output lzwd_pkg::out_t             out_data
);

  localparam int unsigned AW = $clog2(WINDOW_BYTES);
  localparam int unsigned RW = lzwd_pkg::LenW + 1;

  logic [7:0] mem [WINDOW_BYTES];

  // clearing pass
  logic          clr_r, clr_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  // issue stage
  logic                 act_r, act_nxt;
  lzwd_pkg::cmd_kind_t  kind_r, kind_nxt;
  logic [AW-1:0]        off_r, off_nxt;
  logic [RW-1:0]        rem_r, rem_nxt;
  logic                 restart_r, restart_nxt;
  logic [7:0]           lit_r, lit_nxt;

  // write / result stage
  logic                 s2_v_r, s2_v_nxt;
  lzwd_pkg::cmd_kind_t  s2_kind_r;
  logic                 s2_last_r;
  logic                 s2_restart_r;
  logic [7:0]           s2_lit_r;
  logic [7:0]           rdata_r;
  logic                 byp_r;
  logic [7:0]           byp_data_r;

  logic [AW-1:0]        wp_r, wp_nxt;
  logic                 out_valid_r, out_valid_nxt;
  lzwd_pkg::out_t       out_data_r;

  logic                 fire, advance, issue, is_last, we_s2;
  logic [AW-1:0]        wp_base;
  logic [7:0]           val;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [7:0]           mem_wdata;

  assign status.clearing = clr_r;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

  assign fire    = s2_v_r && (!out_valid_r || out_ready);
  assign advance = !s2_v_r || fire;
  assign issue   = act_r && advance && !clr_r;
  assign is_last = (rem_r == '0);
  assign q_pop   = q_valid && !clr_r && (!act_r || (issue && is_last));

  assign wp_base = s2_restart_r ? AW'(1) : wp_r;
  assign we_s2   = fire && (s2_kind_r != lzwd_pkg::CMD_EOS);

  always_comb begin
    case (s2_kind_r)
      lzwd_pkg::CMD_LIT:  val = s2_lit_r;
      lzwd_pkg::CMD_COPY: val = byp_r ? byp_data_r : rdata_r;
      default:            val = 8'd0;
    endcase
  end

  assign mem_we    = clr_r || we_s2;
  assign mem_waddr = clr_r ? clr_addr_r : wp_base;
  assign mem_wdata = clr_r ? 8'd0 : val;

  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(WINDOW_BYTES - 1)) begin
        clr_nxt = 1'b0;
      end
    end

    act_nxt     = act_r;
    kind_nxt    = kind_r;
    off_nxt     = off_r;
    rem_nxt     = rem_r;
    restart_nxt = restart_r;
    lit_nxt     = lit_r;
    if (issue) begin
      off_nxt     = off_r + AW'(1);
      rem_nxt     = rem_r - RW'(1);
      restart_nxt = 1'b0;
      if (is_last) begin
        act_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      act_nxt     = 1'b1;
      kind_nxt    = q_cmd.kind;
      off_nxt     = AW'(q_cmd.offset);
      restart_nxt = q_cmd.restart;
      lit_nxt     = q_cmd.lit;
      rem_nxt     = (q_cmd.kind == lzwd_pkg::CMD_COPY) ?
                    ({1'b0, q_cmd.len_code} + RW'(1)) : '0;
    end

    s2_v_nxt = issue ? 1'b1 : (fire ? 1'b0 : s2_v_r);

    wp_nxt = wp_r;
    if (fire) begin
      wp_nxt = we_s2 ? wp_base + AW'(1) : wp_base;
    end

    out_valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // window memory, registered read with same-cycle write forwarding
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rdata_r    <= mem[off_r];
      byp_r      <= mem_we && (mem_waddr == off_r);
      byp_data_r <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_kind_r    <= kind_r;
      s2_last_r    <= is_last;
      s2_restart_r <= restart_r;
      s2_lit_r     <= lit_r;
    end
    if (q_pop) begin
      kind_r <= kind_nxt;
      lit_r  <= lit_nxt;
    end
    off_r     <= off_nxt;
    rem_r     <= rem_nxt;
    if (fire) begin
      out_data_r.out_byte      <= val;
      out_data_r.last_of_run   <= s2_last_r;
      out_data_r.end_of_stream <= (s2_kind_r == lzwd_pkg::CMD_EOS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_addr_r  <= '0;
      act_r       <= 1'b0;
      restart_r   <= 1'b0;
      s2_v_r      <= 1'b0;
      wp_r        <= AW'(1);
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      clr_addr_r  <= clr_addr_nxt;
      act_r       <= act_nxt;
      restart_r   <= restart_nxt;
      s2_v_r      <= s2_v_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/lzwd_window_decompressor_core.sv
`default_nettype none
// channel   ports                            beat carries
// input     in_valid / in_ready / in_data    one compressed byte, start_of_chunk
// result    out_valid / out_ready / out_data one decoded byte, last_of_run, end_of_stream
//
// after reset a clearing pass zeroes the window, with in_ready low meanwhile
// the front takes one compressed byte per cycle while the command queue has room and no clearing pass runs
// the back gives one result per cycle unless the output stalls or the queue runs dry;
// the window memory has one write port and one registered read port
// either side may stall; the queue and the output register decouple the two
// reset is synchronous, active low; the window contents survive start_of_chunk
module lzss_window_decompressor_core #(
  parameter int unsigned WINDOW_BYTES = lzwd_pkg::WindowBytes
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire lzwd_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output lzwd_pkg::out_t      out_data
);

  lzwd_pkg::back_status_t status;
  lzwd_pkg::cmd_t         push_cmd;
  lzwd_pkg::cmd_t         head_cmd;
  logic                   q_push, q_full, q_pop, q_valid;

  lzwd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .status   (status),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  lzwd_cmd_fifo #(
    .DEPTH (lzwd_pkg::QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  lzwd_back #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
